### sv/gspl_pkg.sv
// ----------------------------------------------------------------------------
// gspl_pkg: shared types and constants for the grid shortest path core
// Grid geometry, field widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package gspl_pkg;

  // Grid geometry: a cell address is {row, col}
  localparam int COORD_W    = 6;
  localparam int GRID_DIM   = 64;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int CELL_COUNT = 2 ** ADDR_W;
  localparam logic [COORD_W:0] GRID_DIM_C = (COORD_W + 1)'(GRID_DIM);

  // Step count field
  localparam int LEN_W = 12;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Frontier entry: cell address over distance
  localparam int QENT_W = ADDR_W + LEN_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRANCE_ROW = 2'd0,
    CFG_ENTRANCE_COL = 2'd1,
    CFG_EXIT_ROW     = 2'd2,
    CFG_EXIT_COL     = 2'd3
  } cfg_index_t;

  // Neighbor directions, visited in this order
  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_EAST  = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR_ALL,
    ST_IDLE,
    ST_CLEAR_VIS,
    ST_SEED,
    ST_POP,
    ST_LOAD,
    ST_NB_RD,
    ST_NB_CHK,
    ST_DONE
  } state_t;

endpackage

### sv/gspl_ram.sv
// ----------------------------------------------------------------------------
// gspl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module gspl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/grid_shortest_path_length_core.sv
// ----------------------------------------------------------------------------
// grid_shortest_path_length_core: shortest 4-connected path length on a grid
// Holds a 64x64 map of free and blocked cells, written one cell per word.
// A run word does a breadth-first walk from the entrance to the exit and
// returns whether the exit is reachable and the least step count.
//
//   channel | words                                   | handshake
//   --------+-----------------------------------------+-------------------
//   in      | mode, cell_row, cell_col, cell_blocked  | in_valid/in_ready
//   out     | path_found, step_count                  | out_valid/out_ready
//   cfg     | cfg_index, cfg_data                     | cfg_valid/cfg_ready
//
// After reset a clearing pass empties the cell map and the visited map;
// in_ready stays low meanwhile (cfg writes are taken). A run with the
// entrance on the exit goes straight to the result. Any other run clears
// the visited map, seeds the queue with the entrance, then pops each
// queued cell, loads it and probes its four directions in turn: an
// off-grid direction is skipped, an in-grid neighbor is read from the maps
// and checked, and the walk ends at the exit or on an empty queue.
// A finished result waits in the output register; a second run may start,
// but its result is held until the first word is taken.
// ----------------------------------------------------------------------------
module grid_shortest_path_length_core (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [gspl_pkg::COORD_W-1:0]  cell_row,
  input  logic [gspl_pkg::COORD_W-1:0]  cell_col,
  input  logic                          cell_blocked,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          path_found,
  output logic [gspl_pkg::LEN_W-1:0]    step_count,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gspl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gspl_pkg::COORD_W-1:0]  cfg_data
);

  gspl_pkg::state_t state, state_next;

  // Configuration registers
  logic [gspl_pkg::COORD_W-1:0] entrance_row, entrance_col, exit_row, exit_col;

  // Walk registers
  logic [gspl_pkg::ADDR_W-1:0]  sweep;
  logic [gspl_pkg::ADDR_W:0]    head, tail;
  logic [gspl_pkg::COORD_W-1:0] cur_row, cur_col;
  logic [gspl_pkg::LEN_W-1:0]   cur_dist;
  gspl_pkg::dir_t               dir;
  logic [gspl_pkg::LEN_W-1:0]   result_len;

  // RAM ports
  logic                          cell_we, vis_we, q_we;
  logic [gspl_pkg::ADDR_W-1:0]   cell_waddr, vis_waddr, q_waddr, q_raddr;
  logic                          cell_wdata, vis_wdata, cell_rdata, vis_rdata;
  logic [gspl_pkg::QENT_W-1:0]   q_wdata, q_rdata;

  // Datapath helpers
  logic                          in_take, run_take, run_bad, out_load;
  logic                          sweep_last, queue_empty, last_dir, nb_free;
  logic                          nb_ok, nb_goal;
  logic [gspl_pkg::COORD_W-1:0]  nb_row, nb_col;
  logic [gspl_pkg::ADDR_W-1:0]   nb_addr, start_addr;
  logic [gspl_pkg::LEN_W:0]      dist_inc;
  logic [gspl_pkg::LEN_W-1:0]    dist_sat;

  assign cfg_ready = 1'b1;

  assign in_take    = in_valid && in_ready;
  assign run_take   = in_take && mode;
  assign sweep_last = (sweep == gspl_pkg::ADDR_W'(gspl_pkg::CELL_COUNT - 1));
  assign queue_empty = (head == tail);
  assign last_dir   = (dir == gspl_pkg::DIR_WEST);
  assign start_addr = {entrance_row, entrance_col};
  assign nb_addr    = {nb_row, nb_col};
  assign nb_goal    = (nb_row == exit_row) && (nb_col == exit_col);
  assign nb_free    = !vis_rdata && !cell_rdata;
  assign out_load   = (state == gspl_pkg::ST_DONE) && (!out_valid || out_ready);

  // Entrance or exit off the grid, or entrance on the exit: no path
  assign run_bad = !({1'b0, entrance_row} < gspl_pkg::GRID_DIM_C) ||
                   !({1'b0, entrance_col} < gspl_pkg::GRID_DIM_C) ||
                   !({1'b0, exit_row} < gspl_pkg::GRID_DIM_C) ||
                   !({1'b0, exit_col} < gspl_pkg::GRID_DIM_C) ||
                   ((entrance_row == exit_row) && (entrance_col == exit_col));

  // Saturating step count one past the current cell
  assign dist_inc = {1'b0, cur_dist} + (gspl_pkg::LEN_W + 1)'(1);
  assign dist_sat = dist_inc[gspl_pkg::LEN_W] ? gspl_pkg::LEN_MAX
                                              : dist_inc[gspl_pkg::LEN_W-1:0];

  // Neighbor generator, one direction per probe
  always_comb begin
    nb_row = cur_row;
    nb_col = cur_col;
    nb_ok  = 1'b0;
    unique case (dir)
      gspl_pkg::DIR_NORTH: begin
        nb_ok  = (cur_row != '0);
        nb_row = cur_row - gspl_pkg::COORD_W'(1);
      end
      gspl_pkg::DIR_SOUTH: begin
        nb_ok  = (({1'b0, cur_row} + (gspl_pkg::COORD_W + 1)'(1)) < gspl_pkg::GRID_DIM_C);
        nb_row = cur_row + gspl_pkg::COORD_W'(1);
      end
      gspl_pkg::DIR_EAST: begin
        nb_ok  = (({1'b0, cur_col} + (gspl_pkg::COORD_W + 1)'(1)) < gspl_pkg::GRID_DIM_C);
        nb_col = cur_col + gspl_pkg::COORD_W'(1);
      end
      gspl_pkg::DIR_WEST: begin
        nb_ok  = (cur_col != '0);
        nb_col = cur_col - gspl_pkg::COORD_W'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gspl_pkg::ST_CLEAR_ALL: if (sweep_last) state_next = gspl_pkg::ST_IDLE;
      gspl_pkg::ST_IDLE: begin
        if (run_take) begin
          state_next = run_bad ? gspl_pkg::ST_DONE : gspl_pkg::ST_CLEAR_VIS;
        end
      end
      gspl_pkg::ST_CLEAR_VIS: if (sweep_last) state_next = gspl_pkg::ST_SEED;
      gspl_pkg::ST_SEED: state_next = gspl_pkg::ST_POP;
      gspl_pkg::ST_POP: begin
        state_next = queue_empty ? gspl_pkg::ST_DONE : gspl_pkg::ST_LOAD;
      end
      gspl_pkg::ST_LOAD: state_next = gspl_pkg::ST_NB_RD;
      gspl_pkg::ST_NB_RD: begin
        priority if (nb_ok && nb_goal) begin
          state_next = gspl_pkg::ST_DONE;
        end else if (nb_ok) begin
          state_next = gspl_pkg::ST_NB_CHK;
        end else if (last_dir) begin
          state_next = gspl_pkg::ST_POP;
        end
      end
      gspl_pkg::ST_NB_CHK: begin
        state_next = last_dir ? gspl_pkg::ST_POP : gspl_pkg::ST_NB_RD;
      end
      gspl_pkg::ST_DONE: if (out_load) state_next = gspl_pkg::ST_IDLE;
      default: state_next = gspl_pkg::ST_CLEAR_ALL;
    endcase
  end

  // Outputs of the sequencer: handshake and RAM controls
  always_comb begin
    in_ready   = 1'b0;
    cell_we    = 1'b0;
    cell_waddr = sweep;
    cell_wdata = 1'b0;
    vis_we     = 1'b0;
    vis_waddr  = sweep;
    vis_wdata  = 1'b0;
    q_we       = 1'b0;
    q_waddr    = tail[gspl_pkg::ADDR_W-1:0];
    q_wdata    = {nb_addr, dist_sat};
    q_raddr    = head[gspl_pkg::ADDR_W-1:0];
    unique case (state)
      gspl_pkg::ST_CLEAR_ALL: begin
        cell_we = 1'b1;
        vis_we  = 1'b1;
      end
      gspl_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cell_we    = in_valid && !mode &&
                     ({1'b0, cell_row} < gspl_pkg::GRID_DIM_C) &&
                     ({1'b0, cell_col} < gspl_pkg::GRID_DIM_C);
        cell_waddr = {cell_row, cell_col};
        cell_wdata = cell_blocked;
      end
      gspl_pkg::ST_CLEAR_VIS: vis_we = 1'b1;
      gspl_pkg::ST_SEED: begin
        vis_we    = 1'b1;
        vis_waddr = start_addr;
        vis_wdata = 1'b1;
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = {start_addr, gspl_pkg::LEN_W'(0)};
      end
      gspl_pkg::ST_NB_CHK: begin
        // push a free, unseen neighbor
        vis_we    = nb_free;
        vis_waddr = nb_addr;
        vis_wdata = 1'b1;
        q_we      = nb_free && (tail != (gspl_pkg::ADDR_W + 1)'(gspl_pkg::CELL_COUNT));
      end
      gspl_pkg::ST_POP, gspl_pkg::ST_LOAD, gspl_pkg::ST_NB_RD, gspl_pkg::ST_DONE: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gspl_pkg::ST_CLEAR_ALL;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entrance_row <= '0;
      entrance_col <= '0;
      exit_row     <= '0;
      exit_col     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gspl_pkg::cfg_index_t'(cfg_index))
        gspl_pkg::CFG_ENTRANCE_ROW: entrance_row <= cfg_data;
        gspl_pkg::CFG_ENTRANCE_COL: entrance_col <= cfg_data;
        gspl_pkg::CFG_EXIT_ROW:     exit_row     <= cfg_data;
        gspl_pkg::CFG_EXIT_COL:     exit_col     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sweep counter for the clearing passes
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (state == gspl_pkg::ST_CLEAR_ALL || state == gspl_pkg::ST_CLEAR_VIS) begin
      sweep <= sweep + gspl_pkg::ADDR_W'(1);
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (state == gspl_pkg::ST_SEED) begin
        head <= '0;
        tail <= (gspl_pkg::ADDR_W + 1)'(1);
      end else begin
        if (state == gspl_pkg::ST_POP && !queue_empty) begin
          head <= head + (gspl_pkg::ADDR_W + 1)'(1);
        end
        if (q_we) begin
          tail <= tail + (gspl_pkg::ADDR_W + 1)'(1);
        end
      end
    end
  end

  // Current cell, direction and search result
  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= gspl_pkg::DIR_NORTH;
    end else begin
      unique case (state)
        gspl_pkg::ST_LOAD: begin
          dir <= gspl_pkg::DIR_NORTH;
        end
        gspl_pkg::ST_NB_RD: begin
          if (!nb_ok) dir <= gspl_pkg::dir_t'(dir + 2'd1);
        end
        gspl_pkg::ST_NB_CHK: begin
          dir <= gspl_pkg::dir_t'(dir + 2'd1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == gspl_pkg::ST_LOAD) begin
      cur_row  <= q_rdata[gspl_pkg::QENT_W-1 -: gspl_pkg::COORD_W];
      cur_col  <= q_rdata[gspl_pkg::LEN_W +: gspl_pkg::COORD_W];
      cur_dist <= q_rdata[gspl_pkg::LEN_W-1:0];
    end
    // a run with bad coordinates or an empty queue reports no path
    if ((state == gspl_pkg::ST_IDLE) ||
        (state == gspl_pkg::ST_POP && queue_empty)) begin
      result_len <= '0;
    end else if (state == gspl_pkg::ST_NB_RD && nb_ok && nb_goal) begin
      result_len <= dist_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      path_found <= (result_len != '0);
      step_count <= result_len;
    end
  end

  // Cell map, visited map and frontier queue
  gspl_ram #(.WIDTH(1), .DEPTH(gspl_pkg::CELL_COUNT)) u_cell_map (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (nb_addr),
    .rdata (cell_rdata)
  );

  gspl_ram #(.WIDTH(1), .DEPTH(gspl_pkg::CELL_COUNT)) u_visited_map (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (nb_addr),
    .rdata (vis_rdata)
  );

  gspl_ram #(.WIDTH(gspl_pkg::QENT_W), .DEPTH(gspl_pkg::CELL_COUNT)) u_frontier (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

`ifndef ASSERT_OFF
  // the queue never runs past its fill level or its depth
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail) else $error("queue head passed tail");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= (gspl_pkg::ADDR_W + 1)'(gspl_pkg::CELL_COUNT))
    else $error("queue tail beyond depth");

  // seeding leaves exactly the start cell queued
  a_seed: assert property (@(posedge clk) disable iff (rst)
    (state == gspl_pkg::ST_SEED) |=> (tail == (gspl_pkg::ADDR_W + 1)'(1)) && (head == '0))
    else $error("seed did not queue one cell");

  // a shown result reports found exactly when the length is nonzero
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (path_found == (step_count != '0)))
    else $error("path_found disagrees with step_count");
`endif

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for grid_shortest_path_length_core
// Loads walled rooms of random size and fill into the cell map, moves the
// entrance and exit between phases, and runs searches. A breadth-first
// predictor kept in step with every accepted word gives the expected step
// count, which is compared against each result word as it leaves the core.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_RUN   = 1'b1;

  localparam int HOLD_CYCLES  = 20000;     // long receiver stall
  localparam int SETTLE       = 16;        // cycles after the last result
  localparam int LIMIT_CYCLES = 12000000;

  typedef struct packed {
    logic                       found;
    logic [gspl_pkg::LEN_W-1:0] steps;
  } route_t;

  // Cell map, registers and pending search results
  class maze_tracker;
    bit                           blocked_map [gspl_pkg::CELL_COUNT];
    logic [gspl_pkg::COORD_W-1:0] ent_row, ent_col, goal_row, goal_col;
    route_t                       pending_routes [$];
    int unsigned                  faults;

    function new();
      ent_row  = '0;
      ent_col  = '0;
      goal_row = '0;
      goal_col = '0;
      faults   = 0;
    endfunction

    function void set_reg(gspl_pkg::cfg_index_t idx, logic [gspl_pkg::COORD_W-1:0] val);
      case (idx)
        gspl_pkg::CFG_ENTRANCE_ROW: ent_row  = val;
        gspl_pkg::CFG_ENTRANCE_COL: ent_col  = val;
        gspl_pkg::CFG_EXIT_ROW:     goal_row = val;
        gspl_pkg::CFG_EXIT_COL:     goal_col = val;
        default: ;
      endcase
    endfunction

    // Breadth-first walk; exit always counts as passable
    function int unsigned shortest_steps();
      bit          seen [gspl_pkg::CELL_COUNT];
      int unsigned frontier [$];
      int unsigned depth [$];
      int unsigned nbrs [$];
      int unsigned here, hops, r, c, start, goal, nxt;
      if (ent_row >= gspl_pkg::GRID_DIM || ent_col >= gspl_pkg::GRID_DIM ||
          goal_row >= gspl_pkg::GRID_DIM || goal_col >= gspl_pkg::GRID_DIM) return 0;
      if (ent_row == goal_row && ent_col == goal_col) return 0;
      start = ent_row * gspl_pkg::GRID_DIM + ent_col;
      goal  = goal_row * gspl_pkg::GRID_DIM + goal_col;
      seen[start] = 1'b1;
      frontier.insert(frontier.size(), start);
      depth.insert(depth.size(), 0);
      while (frontier.size() != 0) begin
        here = frontier.pop_front();
        hops = depth.pop_front();
        r = here / gspl_pkg::GRID_DIM;
        c = here % gspl_pkg::GRID_DIM;
        nbrs.delete();
        if (r > 0) nbrs.insert(nbrs.size(), here - gspl_pkg::GRID_DIM);
        if (r + 1 < gspl_pkg::GRID_DIM) nbrs.insert(nbrs.size(), here + gspl_pkg::GRID_DIM);
        if (c + 1 < gspl_pkg::GRID_DIM) nbrs.insert(nbrs.size(), here + 1);
        if (c > 0) nbrs.insert(nbrs.size(), here - 1);
        foreach (nbrs[k]) begin
          nxt = nbrs[k];
          if (nxt == goal) return hops + 1;
          if (!seen[nxt] && !blocked_map[nxt]) begin
            seen[nxt] = 1'b1;
            frontier.insert(frontier.size(), nxt);
            depth.insert(depth.size(), hops + 1);
          end
        end
      end
      return 0;
    endfunction

    // Accepted input word: cell write or search
    function void apply_word(logic m, logic [gspl_pkg::COORD_W-1:0] r,
                             logic [gspl_pkg::COORD_W-1:0] c, logic b);
      int unsigned len;
      route_t      exp_route;
      if (m == MODE_WRITE) begin
        if (r < gspl_pkg::GRID_DIM && c < gspl_pkg::GRID_DIM)
          blocked_map[r * gspl_pkg::GRID_DIM + c] = b;
      end else begin
        len = shortest_steps();
        if (len > gspl_pkg::LEN_MAX) len = gspl_pkg::LEN_MAX;
        exp_route.found = (len != 0);
        exp_route.steps = gspl_pkg::LEN_W'(len);
        pending_routes.insert(pending_routes.size(), exp_route);
      end
    endfunction

    function void check_route(logic found, logic [gspl_pkg::LEN_W-1:0] steps);
      route_t exp_route;
      if (pending_routes.size() == 0) begin
        $error("result word with no search pending: path_found=%0d step_count=%0d",
               found, steps);
        faults++;
        return;
      end
      exp_route = pending_routes.pop_front();
      if (found !== exp_route.found) begin
        $error("path_found: expected %0d, actual %0d", exp_route.found, found);
        faults++;
      end
      if (steps !== exp_route.steps) begin
        $error("step_count: expected %0d, actual %0d", exp_route.steps, steps);
        faults++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           mode;
  logic [gspl_pkg::COORD_W-1:0]   cell_row;
  logic [gspl_pkg::COORD_W-1:0]   cell_col;
  logic                           cell_blocked;
  logic                           out_valid;
  logic                           out_ready;
  logic                           path_found;
  logic [gspl_pkg::LEN_W-1:0]     step_count;
  logic                           cfg_valid;
  logic                           cfg_ready;
  gspl_pkg::cfg_index_t           cfg_index;
  logic [gspl_pkg::COORD_W-1:0]   cfg_data;

  maze_tracker maze;
  bit          hold_request;
  bit          src_quiet;
  int unsigned words_sent;
  int unsigned runs_sent;

  grid_shortest_path_length_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .cell_blocked (cell_blocked),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .path_found   (path_found),
    .step_count   (step_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Send one input word, with a random gap first unless in a quiet stretch
  task automatic send_word(logic m, int r, int c, logic b);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    mode         <= m;
    cell_row     <= r[gspl_pkg::COORD_W-1:0];
    cell_col     <= c[gspl_pkg::COORD_W-1:0];
    cell_blocked <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    maze.apply_word(m, r[gspl_pkg::COORD_W-1:0], c[gspl_pkg::COORD_W-1:0], b);
    words_sent++;
    if (m == MODE_RUN) runs_sent++;
  endtask

  task automatic write_reg(gspl_pkg::cfg_index_t idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[gspl_pkg::COORD_W-1:0];
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    maze.set_reg(idx, val[gspl_pkg::COORD_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, let every pending search come back, then settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (maze.pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One phase: a walled room of side k, random fill, a few searches inside
  task automatic room_trial(bit pressure);
    int          k, r0, c0, ent_r, ent_c, ex_r, ex_c, r, c;
    int unsigned sel, side, dens, nruns, slot, leak_slot, first;
    bit          leaky;
    wait_drained();
    src_quiet = ($urandom_range(0, 3) == 0);
    leaky     = !pressure && ($urandom_range(0, 15) == 0);
    if (pressure) k = 2;
    else if ($urandom_range(0, 9) == 0) k = $urandom_range(7, 12);
    else k = $urandom_range(1, 6);
    sel = $urandom_range(0, 3);
    r0  = (sel == 0) ? 0 : (sel == 1) ? gspl_pkg::GRID_DIM - k
                                      : $urandom_range(0, gspl_pkg::GRID_DIM - k);
    sel = $urandom_range(0, 3);
    c0  = (sel == 0) ? 0 : (sel == 1) ? gspl_pkg::GRID_DIM - k
                                      : $urandom_range(0, gspl_pkg::GRID_DIM - k);
    ent_r = r0 + $urandom_range(0, k - 1);
    ent_c = c0 + $urandom_range(0, k - 1);

    // exit: inside, on the ring, anywhere, on the entrance, or at a corner
    sel  = pressure ? 0 : $urandom_range(0, 9);
    ex_r = r0 + $urandom_range(0, k - 1);
    ex_c = c0 + $urandom_range(0, k - 1);
    if (sel == 5 || sel == 6) begin
      side = $urandom_range(0, 3);
      case (side)
        0: if (r0 > 0) ex_r = r0 - 1;
        1: if (r0 + k < gspl_pkg::GRID_DIM) ex_r = r0 + k;
        2: if (c0 > 0) ex_c = c0 - 1;
        default: if (c0 + k < gspl_pkg::GRID_DIM) ex_c = c0 + k;
      endcase
    end else if (sel == 7) begin
      ex_r = $urandom_range(0, gspl_pkg::GRID_DIM - 1);
      ex_c = $urandom_range(0, gspl_pkg::GRID_DIM - 1);
    end else if (sel == 8) begin
      ex_r = ent_r;
      ex_c = ent_c;
    end else if (sel == 9) begin
      ex_r = $urandom_range(0, 1) ? gspl_pkg::GRID_DIM - 1 : 0;
      ex_c = $urandom_range(0, 1) ? gspl_pkg::GRID_DIM - 1 : 0;
    end

    // registers, in a rotated order
    first = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      case ((first + i) % 4)
        0: write_reg(gspl_pkg::CFG_ENTRANCE_ROW, ent_r);
        1: write_reg(gspl_pkg::CFG_ENTRANCE_COL, ent_c);
        2: write_reg(gspl_pkg::CFG_EXIT_ROW, ex_r);
        default: write_reg(gspl_pkg::CFG_EXIT_COL, ex_c);
      endcase
    end

    // stray writes anywhere in the grid
    repeat ($urandom_range(0, 6))
      send_word(MODE_WRITE, $urandom_range(0, gspl_pkg::GRID_DIM - 1),
                $urandom_range(0, gspl_pkg::GRID_DIM - 1), 1'($urandom_range(0, 1)));

    // ring of walls; a leaky room leaves one of them open
    slot      = 0;
    leak_slot = $urandom_range(0, 4 * k - 1);
    for (r = r0 - 1; r <= r0 + k; r++) begin
      for (c = c0 - 1; c <= c0 + k; c++) begin
        if (r >= 0 && r < gspl_pkg::GRID_DIM && c >= 0 && c < gspl_pkg::GRID_DIM &&
            (r == r0 - 1 || r == r0 + k || c == c0 - 1 || c == c0 + k)) begin
          send_word(MODE_WRITE, r, c, !(leaky && slot == leak_slot));
          slot++;
        end
      end
    end

    // room fill
    dens = $urandom_range(0, 45);
    for (r = r0; r < r0 + k; r++)
      for (c = c0; c < c0 + k; c++)
        send_word(MODE_WRITE, r, c, $urandom_range(0, 99) < dens);

    // searches, with a few cells changed before each
    nruns = pressure ? 5 : leaky ? 1 : $urandom_range(1, 3);
    if (pressure) hold_request = 1'b1;
    repeat (nruns) begin
      repeat ($urandom_range(0, 3))
        send_word(MODE_WRITE, r0 + $urandom_range(0, k - 1), c0 + $urandom_range(0, k - 1),
                  $urandom_range(0, 99) < dens);
      send_word(MODE_RUN, $urandom_range(0, gspl_pkg::GRID_DIM - 1),
                $urandom_range(0, gspl_pkg::GRID_DIM - 1), 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: random ready gaps, quiet stretches and one long hold-off
  initial begin : result_sink
    int unsigned gap;
    bit          quiet;
    out_ready = 1'b0;
    quiet     = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      maze.check_route(path_found, step_count);
    end
  end

  initial begin : stimulus
    int unsigned trial;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_WRITE;
    cell_row     = '0;
    cell_col     = '0;
    cell_blocked = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = gspl_pkg::CFG_ENTRANCE_ROW;
    cfg_data     = '0;
    hold_request = 1'b0;
    src_quiet    = 1'b0;
    words_sent   = 0;
    runs_sent    = 0;
    maze = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset: entrance on the exit, so no path
    send_word(MODE_WRITE, 0, 0, 1'b1);
    send_word(MODE_RUN, gspl_pkg::GRID_DIM - 1, gspl_pkg::GRID_DIM - 1, 1'b1);
    wait_drained();

    // corner to corner over the open grid from a blocked entrance
    write_reg(gspl_pkg::CFG_EXIT_ROW, gspl_pkg::GRID_DIM - 1);
    write_reg(gspl_pkg::CFG_EXIT_COL, gspl_pkg::GRID_DIM - 1);
    send_word(MODE_RUN, 0, 0, 1'b0);
    // a blocked exit is still reached
    send_word(MODE_WRITE, gspl_pkg::GRID_DIM - 1, gspl_pkg::GRID_DIM - 1, 1'b1);
    send_word(MODE_RUN, 0, 0, 1'b0);
    wait_drained();

    // exit right next to the entrance: one step, blocked or not
    write_reg(gspl_pkg::CFG_ENTRANCE_ROW, gspl_pkg::GRID_DIM - 1);
    write_reg(gspl_pkg::CFG_ENTRANCE_COL, gspl_pkg::GRID_DIM - 1);
    write_reg(gspl_pkg::CFG_EXIT_ROW, gspl_pkg::GRID_DIM - 2);
    send_word(MODE_RUN, 0, gspl_pkg::GRID_DIM - 1, 1'b0);
    send_word(MODE_WRITE, gspl_pkg::GRID_DIM - 2, gspl_pkg::GRID_DIM - 1, 1'b1);
    send_word(MODE_RUN, gspl_pkg::GRID_DIM - 1, 0, 1'b1);
    send_word(MODE_WRITE, gspl_pkg::GRID_DIM - 1, gspl_pkg::GRID_DIM - 2, 1'b1);
    wait_drained();

    // entrance sealed in its corner: far exit unreachable
    write_reg(gspl_pkg::CFG_EXIT_ROW, 0);
    write_reg(gspl_pkg::CFG_EXIT_COL, 0);
    send_word(MODE_RUN, 0, 0, 1'b0);
    send_word(MODE_WRITE, 0, 0, 1'b0);

    // random rooms; the third one carries the receiver hold-off
    trial = 0;
    while (words_sent < 1700 || runs_sent < 48) begin
      room_trial(trial == 2);
      trial++;
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (maze.faults == 0 && maze.pending_routes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
